// ===== hw/rtl/led_strip_two_head_scan_top_defines.svh =====
// Assertion macros used by the scanner back end RTL.
`ifndef LED_STRIP_TWO_HEAD_SCAN_TOP_DEFINES_SVH
`define LED_STRIP_TWO_HEAD_SCAN_TOP_DEFINES_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define LSTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define LSTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lsts_pkg.sv =====
// Shared types and constants of the two-head scanner.
package lsts_pkg;
    localparam int LEDS  = 45;
    localparam int IDX_W = $clog2(LEDS);
    localparam int HALF  = LEDS / 2;

    localparam logic [7:0]  MIN_RATE   = 8'd20;
    localparam logic [31:0] MS_PER_MIN = 32'd60000;
    localparam logic [7:0]  FULL_RED   = 8'd255;

    localparam logic CFG_OFFSET = 1'b0;
    localparam logic CFG_FADE   = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] head_a;
        logic [IDX_W-1:0] head_b;
        logic             fade;
    } t_job;

    typedef enum logic [2:0] {
        F_IDLE, F_DIV_PER, F_DIV_PH, F_DIV_ADV, F_PUSH
    } t_front_state;

    typedef enum logic {
        B_IDLE, B_EXEC
    } t_back_state;
endpackage

// ===== hw/rtl/lsts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lsts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 45
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/lsts_front.sv =====
// Front end: accept a frame request, find both head positions with a shared divider.
module lsts_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [31:0]   i_now_ms,
    input  logic [7:0]    i_beat_rate,
    input  logic          i_q_full,
    output logic          o_push,
    output lsts_pkg::t_job o_job
);
    import lsts_pkg::*;

    t_front_state r_state, n_state;
    logic [31:0] r_dvd;
    logic [15:0] r_dvs;
    logic [15:0] r_rem;
    logic [31:0] r_quo;
    logic [4:0]  r_cnt;
    logic [31:0] r_now;
    logic [31:0] r_last;
    logic        r_fade;
    t_job        r_job;

    logic        w_accept;
    logic        w_last_step;
    logic [16:0] w_rem_sh;
    logic        w_ge;
    logic [15:0] w_rem_nx;
    logic [31:0] w_quo_nx;
    logic [7:0]  w_rate;
    logic [31:0] w_hb;

    // One restoring-division bit per cycle.
    assign w_rem_sh    = {r_rem, r_dvd[31]};
    assign w_ge        = w_rem_sh >= {1'b0, r_dvs};
    assign w_rem_nx    = w_ge ? 16'(w_rem_sh - {1'b0, r_dvs}) : w_rem_sh[15:0];
    assign w_quo_nx    = {r_quo[30:0], w_ge};
    assign w_last_step = r_cnt == 5'd31;
    assign w_rate      = (i_beat_rate < MIN_RATE) ? MIN_RATE : i_beat_rate;
    assign w_hb        = w_quo_nx + 32'(HALF);

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:    if (i_in_valid) n_state = F_DIV_PER;
            F_DIV_PER: if (w_last_step) n_state = F_DIV_PH;
            F_DIV_PH:  if (w_last_step) n_state = F_DIV_ADV;
            F_DIV_ADV: if (w_last_step) n_state = F_PUSH;
            F_PUSH:    if (!i_q_full) n_state = F_IDLE;
            default:   n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = r_state != F_IDLE;
        o_push     = (r_state == F_PUSH) && !i_q_full;
    end

    assign w_accept = i_in_valid && !o_in_stall;
    assign o_job    = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_last <= i_now_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now  <= i_now_ms;
            r_fade <= i_now_ms != r_last;
            r_dvd  <= MS_PER_MIN;
            r_dvs  <= {8'd0, w_rate};
            r_rem  <= '0;
            r_quo  <= '0;
            r_cnt  <= '0;
        end else if (r_state == F_DIV_PER || r_state == F_DIV_PH
                     || r_state == F_DIV_ADV) begin
            r_cnt <= r_cnt + 5'd1;
            if (!w_last_step) begin
                r_dvd <= {r_dvd[30:0], 1'b0};
                r_rem <= w_rem_nx;
                r_quo <= w_quo_nx;
            end else begin
                r_rem <= '0;
                r_quo <= '0;
                case (r_state)
                    F_DIV_PER: begin
                        r_dvs <= w_quo_nx[15:0];
                        r_dvd <= r_now;
                    end
                    F_DIV_PH: begin
                        // Phase times half a strip can exceed 16 bits.
                        r_dvd <= 32'(w_rem_nx) * 32'(HALF);
                    end
                    default: begin
                        r_job.fade   <= r_fade;
                        r_job.head_a <= (w_quo_nx >= 32'(LEDS)) ? IDX_W'(LEDS - 1)
                                                               : w_quo_nx[IDX_W-1:0];
                        r_job.head_b <= (w_hb >= 32'(LEDS)) ? IDX_W'(LEDS - 1)
                                                            : w_hb[IDX_W-1:0];
                    end
                endcase
            end
        end
    end
endmodule

// ===== hw/rtl/lsts_queue.sv =====
// Two-entry job queue between front and back end.
module lsts_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lsts_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output lsts_pkg::t_job o_job
);
    import lsts_pkg::*;

    t_job       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_job;
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_ent[r_rp];
endmodule

// ===== hw/rtl/lsts_back.sv =====
// Back end: fade, paint heads and stream every pixel of the strip.
`include "led_strip_two_head_scan_top_defines.svh"
module lsts_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  lsts_pkg::t_job i_job,
    output logic           o_pop,
    input  logic [7:0]     i_strip_offset,
    input  logic [7:0]     i_fade_step,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_pixel_index,
    output logic [7:0]     o_red,
    output logic [7:0]     o_green,
    output logic [7:0]     o_blue,
    output logic           o_last_pixel
);
    import lsts_pkg::*;

    t_back_state r_state, n_state;
    logic [IDX_W-1:0] r_idx;
    logic [LEDS-1:0]  r_vld;
    logic             r_out_valid;
    logic [7:0]       r_out_idx;
    logic [7:0]       r_out_red;
    logic             r_out_last;

    logic             w_adv;
    logic             w_last;
    logic [IDX_W-1:0] w_raddr;
    logic [7:0]       w_rdata;
    logic [7:0]       w_old;
    logic [7:0]       w_new;

    lsts_ram #(.WIDTH(8), .DEPTH(LEDS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_adv),
        .i_waddr (r_idx),
        .i_wdata (w_new),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Green and blue are only ever painted zero, so only red is stored.
    assign w_last = r_idx == IDX_W'(LEDS - 1);
    assign w_old  = r_vld[r_idx] ? w_rdata : 8'd0;

    always_comb begin
        if (r_idx == i_job.head_a || r_idx == i_job.head_b) begin
            w_new = FULL_RED;
        end else if (i_job.fade) begin
            w_new = (w_old > i_fade_step) ? 8'(w_old - i_fade_step) : 8'd0;
        end else begin
            w_new = w_old;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (i_job_valid) n_state = B_EXEC;
            B_EXEC:  if (w_adv && w_last) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        w_adv   = (r_state == B_EXEC) && (!r_out_valid || !i_out_stall);
        o_pop   = w_adv && w_last;
        w_raddr = r_idx;
        if (w_adv) begin
            w_raddr = w_last ? '0 : IDX_W'(r_idx + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_idx       <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_adv) begin
                r_idx        <= w_raddr;
                r_vld[r_idx] <= 1'b1;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_idx  <= 8'(i_strip_offset + 8'(r_idx));
            r_out_red  <= w_new;
            r_out_last <= w_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_out_idx;
    assign o_red         = r_out_red;
    assign o_green       = 8'd0;
    assign o_blue        = 8'd0;
    assign o_last_pixel  = r_out_last;

    `LSTS_ASSERT_NOW(a_exec_has_job, r_state == B_EXEC, i_job_valid, "back end runs without a job")
    `LSTS_ASSERT_NOW(a_idx_range, 1'b1, r_idx <= IDX_W'(LEDS - 1), "pixel index out of range")
    `LSTS_ASSERT_NEXT(a_pop_idle, o_pop, r_state == B_IDLE && r_idx == '0, "no return to idle")
    `LSTS_ASSERT_NOW(a_idle_idx, r_state == B_IDLE, r_idx == '0, "idle with nonzero index")
endmodule

// ===== hw/rtl/led_strip_two_head_scan_top.sv =====
// Top level of the two-head comet scanner with fading trail.
//
// Input channel: one item is a frame request (now_ms, beat_rate), taken when
// i_in_valid is high and o_in_stall is low. Output channel: one item per
// pixel, 45 per frame in logical order, with its physical index; the last
// carries o_last_pixel. Taken when o_out_valid is high and i_out_stall low.
// Configuration: write i_cfg_data to register i_cfg_idx (0 strip offset,
// 1 fade step) when i_cfg_we is high, only while the block is idle.
// The front end works through three passes of one shared 32-bit bit-serial
// divider: period, phase, head position, then a queue push. After the push,
// the job goes through the queue and the back end into the output register.
// The front end takes a new request only once the last is pushed; the back
// end streams one pixel per cycle into the output register unless stalled.
// A two-entry queue decouples the two ends, so a new request is taken while
// pixels of an earlier frame still go out.
// Reset: the color store reads as cleared through per-pixel valid bits; the
// fade time is zero, registers return to offset 10 and fade step 3.
// A stalled receiver holds the output register; the back end then pauses,
// the queue fills, and finally the input stalls.
module led_strip_two_head_scan_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_beat_rate,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_pixel_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_last_pixel,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import lsts_pkg::*;

    logic [7:0] r_strip_offset;
    logic [7:0] r_fade_step;
    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_qvalid;
    t_job       w_front_job;
    t_job       w_back_job;

    // Configuration registers; drop nothing, no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_offset <= 8'd10;
            r_fade_step    <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OFFSET: r_strip_offset <= i_cfg_data;
                CFG_FADE:   r_fade_step    <= i_cfg_data;
                default:    r_fade_step    <= r_fade_step;
            endcase
        end
    end

    // Classify the request and compute head positions.
    lsts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_now_ms    (i_now_ms),
        .i_beat_rate (i_beat_rate),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_job       (w_front_job)
    );

    // Hold up to two pending frames.
    lsts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_job   (w_back_job)
    );

    // Fade, paint and stream the pixels.
    lsts_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_qvalid),
        .i_job          (w_back_job),
        .o_pop          (w_pop),
        .i_strip_offset (r_strip_offset),
        .i_fade_step    (r_fade_step),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_index  (o_pixel_index),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_last_pixel   (o_last_pixel)
    );
endmodule

// ===== dv/led_strip_two_head_scan_top_tb.sv =====
// Self-checking testbench of the two-head comet scanner: frame scoreboard plus drivers.
`timescale 1ns / 1ps

// Frame scoreboard: keeps its own color store and fade time, expands each
// accepted frame request into the pixels it must produce.
class frame_scoreboard;
    localparam int NPIX = lsts_pkg::LEDS;

    logic [7:0]  offset;
    logic [7:0]  fade;
    logic [7:0]  red_mem [NPIX];
    logic [7:0]  grn_mem [NPIX];
    logic [7:0]  blu_mem [NPIX];
    logic [31:0] fade_time;
    logic [32:0] pixel_q [$];   // {last, index, r, g, b} packed
    int          errors;
    int          checked;

    function new();
        offset    = 8'd10;
        fade      = 8'd3;
        fade_time = '0;
        errors    = 0;
        checked   = 0;
        for (int i = 0; i < NPIX; i++) begin
            red_mem[i] = '0;
            grn_mem[i] = '0;
            blu_mem[i] = '0;
        end
    endfunction

    function automatic logic [7:0] sub_sat(logic [7:0] v, logic [7:0] d);
        return (v > d) ? v - d : 8'd0;
    endfunction

    // Note one accepted frame request and queue its pixels.
    function void note_frame(logic [31:0] now_ms, logic [7:0] rate);
        logic [31:0] r;
        logic [31:0] period;
        logic [31:0] phase;
        logic [31:0] ha;
        logic [31:0] hb;
        logic [7:0]  idx;
        r = (rate < lsts_pkg::MIN_RATE) ? 32'(lsts_pkg::MIN_RATE) : 32'(rate);
        period = lsts_pkg::MS_PER_MIN / r;
        phase  = now_ms % period;
        ha = (phase * lsts_pkg::HALF) / period;
        hb = ha + lsts_pkg::HALF;
        if (ha >= NPIX) ha = NPIX - 1;
        if (hb >= NPIX) hb = NPIX - 1;
        if (now_ms != fade_time) begin
            fade_time = now_ms;
            for (int i = 0; i < NPIX; i++) begin
                red_mem[i] = sub_sat(red_mem[i], fade);
                grn_mem[i] = sub_sat(grn_mem[i], fade);
                blu_mem[i] = sub_sat(blu_mem[i], fade);
            end
        end
        red_mem[ha] = lsts_pkg::FULL_RED;
        grn_mem[ha] = '0;
        blu_mem[ha] = '0;
        red_mem[hb] = lsts_pkg::FULL_RED;
        grn_mem[hb] = '0;
        blu_mem[hb] = '0;
        for (int i = 0; i < NPIX; i++) begin
            idx = offset + 8'(i);
            pixel_q.push_back({i == NPIX - 1, idx, red_mem[i], grn_mem[i], blu_mem[i]});
        end
    endfunction

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (pixel %0d)", what, got, want, checked);
    endtask

    // Check one accepted pixel against the oldest expectation.
    task automatic check_pixel(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                               logic [7:0] b, logic last);
        logic [32:0] e;
        if (pixel_q.size() == 0) begin
            report("unexpected pixel, index", idx, 8'd0);
            return;
        end
        e = pixel_q.pop_front();
        if (idx  != e[31:24]) report("pixel_index", idx, e[31:24]);
        if (r    != e[23:16]) report("red", r, e[23:16]);
        if (g    != e[15:8])  report("green", g, e[15:8]);
        if (b    != e[7:0])   report("blue", b, e[7:0]);
        if (last != e[32])    report("last_pixel", 8'(last), 8'(e[32]));
        checked++;
    endtask
endclass

module led_strip_two_head_scan_top_tb;
    import lsts_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_now_ms;
    logic [7:0]  i_beat_rate;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_pixel_index;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        o_last_pixel;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [7:0]  i_cfg_data;

    frame_scoreboard board;
    int  cycles;
    bit  calm;          // no idling in the final part of the run
    int  frames_sent;
    int  random_frames;
    logic [31:0] clock_ms;

    localparam int LIMIT = 400000;

    led_strip_two_head_scan_top dut (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Abort the run at a generous cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Check every accepted pixel; the receiver stalls in random bursts.
    int stall_left;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_pixel(o_pixel_index, o_red, o_green, o_blue, o_last_pixel);
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 10);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Present one frame request, after a random idle gap unless calm, and hold
    // it until accepted; valid stays high afterwards (caller drops it).
    task automatic send_frame(logic [31:0] now_ms, logic [7:0] rate);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_now_ms    <= now_ms;
        i_beat_rate <= rate;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_frame(now_ms, rate);
        frames_sent++;
    endtask

    // Wait until every expected pixel is out and the block is quiet.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pixel_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_OFFSET) board.offset = data;
        else                   board.fade   = data;
    endtask

    // Random frame: mostly a time that advances 1 to 400 ms, sometimes repeats
    // or jumps anywhere; rates mostly in the normal range.
    task automatic random_frame();
        logic [7:0] rate;
        case ($urandom_range(0, 9))
            0:       clock_ms = $urandom();
            1, 2:    clock_ms = clock_ms;
            default: clock_ms = clock_ms + $urandom_range(1, 400);
        endcase
        rate = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(40, 200));
        send_frame(clock_ms, rate);
    endtask

    initial begin
        board         = new();
        cycles        = 0;
        calm          = 1'b0;
        frames_sent   = 0;
        clock_ms      = '0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_now_ms      = '0;
        i_beat_rate   = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_OFFSET;
        i_cfg_data    = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset registers, time zero (no fade), repeated time,
        // low rates, extreme rate and time values.
        send_frame(32'd0, 8'd0);
        send_frame(32'd0, 8'd19);
        send_frame(32'd1, 8'd20);
        send_frame(32'd2999, 8'd20);
        send_frame(32'd235, 8'd255);
        send_frame(32'hFFFF_FFFF, 8'd255);
        send_frame(32'hFFFF_FFFF, 8'd128);
        send_frame(32'h8000_0000, 8'd1);
        send_frame(32'h5555_5555, 8'h55);
        send_frame(32'hAAAA_AAAA, 8'hAA);
        drain();

        // Offset wraps past 255, fade step at its maximum.
        write_reg(CFG_OFFSET, 8'd255);
        write_reg(CFG_FADE, 8'd255);
        send_frame(32'd100, 8'd60);
        send_frame(32'd150, 8'd60);
        send_frame(32'd150, 8'd90);
        drain();

        // Zero offset and zero fade: trail never fades, time still updates.
        write_reg(CFG_OFFSET, 8'd0);
        write_reg(CFG_FADE, 8'd0);
        for (int k = 0; k < 6; k++) send_frame(32'd200 + 32'(k * 37), 8'd120);
        drain();

        // Random phases, each under a new register setting.
        clock_ms      = 32'd1000;
        random_frames = 0;
        for (int phase_n = 0; phase_n < 6; phase_n++) begin
            write_reg(CFG_OFFSET, (phase_n == 2) ? 8'd192 : 8'($urandom_range(0, 255)));
            write_reg(CFG_FADE, (phase_n == 3) ? 8'd1 : 8'($urandom_range(0, 255)));
            if (phase_n == 5) calm = 1'b1;
            for (int k = 0; k < 30; k++) begin
                random_frame();
                random_frames++;
            end
            drain();
        end

        $display("covered %0d frames (%0d random), %0d pixels checked across offsets and fades",
                 frames_sent, random_frames, board.checked);
        if (board.errors == 0 && board.pixel_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("errors %0d, pixels left %0d", board.errors, board.pixel_q.size());
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
